FILE: hw/rtl/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg: shared definitions for the card number Luhn classifier
// Field widths, the cell-to-cell beat, card type codes and digit helpers.
// ----------------------------------------------------------------------------
package cnlc_pkg;

   // Width of the binary card number and of its decimal form.
   localparam int unsigned NUM_W      = 54;
   localparam int unsigned BCD_DIGITS = 17;   // 2^54 stays below 10^17
   localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

   // Default number of low decimal digits that enter the Luhn sum.
   localparam int unsigned MAX_DIGITS_DEF = 16;

   // Width of the Luhn total and of one group of four digit terms.
   localparam int unsigned SUM_W   = 8;
   localparam int unsigned GROUP_W = 6;

   // Card type codes.
   typedef enum logic [1:0] {
      CARD_INVALID = 2'd0,
      CARD_P34_37  = 2'd1,
      CARD_P51_55  = 2'd2,
      CARD_P4      = 2'd3
   } card_type_type;

   // One beat between neighbouring conversion cells.
   typedef struct packed {
      logic             valid;
      logic [NUM_W-1:0] bin;
      logic [BCD_W-1:0] bcd;
   } cell_type;

   // One finished result leaving the check stages.
   typedef struct packed {
      logic          valid;
      card_type_type card_type;
      logic          checksum_ok;
   } result_type;

   // Luhn doubling: twice the digit, less nine when that exceeds nine.
   function automatic logic [3:0] luhn_double(input logic [3:0] d);
      logic [4:0] t;
      t = {d, 1'b0};
      return (t > 5'd9) ? 4'(t - 5'd9) : t[3:0];
   endfunction

   // True when the total is a multiple of ten.
   function automatic logic is_mult10(input logic [SUM_W-1:0] s);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 26; k++) begin
         if (s == SUM_W'(k * 10)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

FILE: hw/rtl/cnlc_cell.sv
// ----------------------------------------------------------------------------
// cnlc_cell: one binary-to-decimal conversion cell
// Applies the add-three correction to every decimal digit and shifts one
// binary bit into the decimal word, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module cnlc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  cnlc_pkg::cell_type cell_i,
   output cnlc_pkg::cell_type cell_o
);

   logic                       valid_ff;
   logic [cnlc_pkg::NUM_W-1:0] bin_ff;
   logic [cnlc_pkg::BCD_W-1:0] bcd_ff;
   logic [cnlc_pkg::NUM_W-1:0] bin_in;
   logic [cnlc_pkg::BCD_W-1:0] bcd_in;
   logic [cnlc_pkg::BCD_W-1:0] adj;

   // Correct each digit of five or more, then shift the next bit in.
   always_comb begin
      for (int k = 0; k < cnlc_pkg::BCD_DIGITS; k++) begin
         adj[4*k +: 4] = (cell_i.bcd[4*k +: 4] >= 4'd5) ?
                         4'(cell_i.bcd[4*k +: 4] + 4'd3) : cell_i.bcd[4*k +: 4];
      end
      bcd_in = {adj[cnlc_pkg::BCD_W-2:0], cell_i.bin[cnlc_pkg::NUM_W-1]};
      bin_in = {cell_i.bin[cnlc_pkg::NUM_W-2:0], 1'b0};
   end

   // Valid bit is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= cell_i.valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (enable) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
      end
   end

   assign cell_o.valid = valid_ff;
   assign cell_o.bin   = bin_ff;
   assign cell_o.bcd   = bcd_ff;

endmodule

FILE: hw/rtl/cnlc_check.sv
// ----------------------------------------------------------------------------
// cnlc_check: Luhn sum and prefix classification
// Two registered stages: digit terms summed in groups of four with the
// prefix tests, then the group total and the multiple-of-ten test.
// ----------------------------------------------------------------------------
module cnlc_check #(
   parameter int unsigned MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  cnlc_pkg::cell_type   cell_i,
   output cnlc_pkg::result_type result_o
);

   localparam int unsigned LUHN_DIGITS = (MAX_DIGITS < cnlc_pkg::BCD_DIGITS) ?
                                         MAX_DIGITS : cnlc_pkg::BCD_DIGITS;
   localparam int unsigned NUM_GROUPS  = (LUHN_DIGITS + 3) / 4;

   logic [3:0]                   dig [cnlc_pkg::BCD_DIGITS];
   logic [cnlc_pkg::GROUP_W-1:0] grp_in [NUM_GROUPS];
   logic [cnlc_pkg::GROUP_W-1:0] grp_ff [NUM_GROUPS];
   cnlc_pkg::card_type_type      type_a_in;
   cnlc_pkg::card_type_type      type_a_ff;
   logic                         valid_a_ff;
   logic [cnlc_pkg::SUM_W-1:0]   total;
   cnlc_pkg::card_type_type      type_b_ff;
   logic                         ok_b_ff;
   logic                         valid_b_ff;
   logic                         top_zero;

   // Split the decimal word into digits.
   always_comb begin
      for (int k = 0; k < cnlc_pkg::BCD_DIGITS; k++) begin
         dig[k] = cell_i.bcd[4*k +: 4];
      end
   end

   // Luhn terms summed in groups of four; every second digit from the right, starting with the second, is doubled.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < 4; j++) begin
            if (4*g + j < LUHN_DIGITS) begin
               grp_in[g] = grp_in[g] + cnlc_pkg::GROUP_W'(
                  (j % 2 == 1) ? cnlc_pkg::luhn_double(dig[4*g + j]) : dig[4*g + j]);
            end
         end
      end
   end

   // Prefix tests in priority order, read off the leading decimal digits.
   always_comb begin
      top_zero  = (dig[16] == 4'd0);
      type_a_in = cnlc_pkg::CARD_INVALID;
      if (top_zero && dig[15] == 4'd0 && dig[14] == 4'd3 &&
          (dig[13] == 4'd4 || dig[13] == 4'd7)) begin
         type_a_in = cnlc_pkg::CARD_P34_37;
      end else if (top_zero && dig[15] == 4'd5 &&
                   dig[14] >= 4'd1 && dig[14] <= 4'd5) begin
         type_a_in = cnlc_pkg::CARD_P51_55;
      end else if ((top_zero && dig[15] == 4'd4) ||
                   (top_zero && dig[15] == 4'd0 && dig[14] == 4'd0 &&
                    dig[13] == 4'd0 && dig[12] == 4'd4)) begin
         type_a_in = cnlc_pkg::CARD_P4;
      end
   end

   // Group total.
   always_comb begin
      total = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         total = total + cnlc_pkg::SUM_W'(grp_ff[g]);
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= cell_i.valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (enable) begin
         grp_ff    <= grp_in;
         type_a_ff <= type_a_in;
         type_b_ff <= type_a_ff;
         ok_b_ff   <= cnlc_pkg::is_mult10(total);
      end
   end

   assign result_o.valid       = valid_b_ff;
   assign result_o.card_type   = type_b_ff;
   assign result_o.checksum_ok = ok_b_ff;

endmodule

FILE: hw/rtl/card_number_luhn_classifier.sv
// Path: an accepted beat passes through the 54 conversion cells, the two check stages and the
// output register before its result shows.
// Throughput: one card number per cycle whenever the skid entry is free.
// A two-entry output buffer holds the pipeline only when both entries are full.
// Reset clears every valid bit; the block can take a beat as soon as reset is released.
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: card type and Luhn check of a binary number
// A chain of conversion cells turns the number into decimal digits, the
// check stages classify the prefix and test the Luhn sum, and an output
// register with a skid entry decouples the result channel.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier #(
   parameter int unsigned MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [cnlc_pkg::NUM_W-1:0] req_card_number,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_card_type,
   output logic                       rsp_checksum_ok
);

   localparam int unsigned NUM_CELLS = cnlc_pkg::NUM_W;

   cnlc_pkg::cell_type      chain [NUM_CELLS+1];
   cnlc_pkg::result_type    res;
   logic                    enable;
   logic                    take;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   cnlc_pkg::card_type_type out_type_ff;
   cnlc_pkg::card_type_type out_type_in;
   logic                    out_ok_ff;
   logic                    out_ok_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   cnlc_pkg::card_type_type skid_type_ff;
   logic                    skid_ok_ff;
   logic                    skid_load;

   // The pipeline moves whenever the skid entry is free.
   assign enable    = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign chain[0].valid = req_valid;
   assign chain[0].bin   = req_card_number;
   assign chain[0].bcd   = '0;

   // Conversion chain, one binary bit per cell.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      cnlc_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
   end

   cnlc_check #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_check (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .cell_i   (chain[NUM_CELLS]),
      .result_o (res)
   );

   // Output register and skid entry.
   always_comb begin
      take          = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_type_in   = out_type_ff;
      out_ok_in     = out_ok_ff;
      skid_valid_in = skid_valid_ff;
      skid_load     = 1'b0;
      if (skid_valid_ff) begin
         if (take) begin
            out_type_in   = skid_type_ff;
            out_ok_in     = skid_ok_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res.valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_type_in  = res.card_type;
            out_ok_in    = res.checksum_ok;
         end else begin
            skid_valid_in = 1'b1;
            skid_load     = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_type_ff <= out_type_in;
      out_ok_ff   <= out_ok_in;
      if (skid_load) begin
         skid_type_ff <= res.card_type;
         skid_ok_ff   <= res.checksum_ok;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_card_type   = out_type_ff;
   assign rsp_checksum_ok = out_ok_ff;

   // The skid entry is only ever used behind a full output register.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a beat while the output register is empty");

   // A held skid entry drains as soon as the output beat is taken.
   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid entry did not drain after the output beat was taken");

   // A stalled result is neither dropped nor replaced.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_card_type) &&
                                    $stable(rsp_checksum_ok)))
      else $error("stalled result changed");

   // A beat leaving the check stages while the output is blocked lands in the skid entry.
   a_no_loss : assert property (@(posedge clock) disable iff (reset)
      (res.valid && enable && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("result beat lost at the output buffer");

endmodule
